// ----- hw/rtl/sha_pkg.sv -----
package sha_pkg;

   typedef enum logic {
      OP_ABSORB = 1'b0,
      OP_FINISH = 1'b1
   } sha_op_type;

   typedef enum logic [1:0] {
      CORE_IDLE,
      CORE_ROUND,
      CORE_ADD
   } sha_core_state_type;

   typedef enum logic [1:0] {
      TOP_IDLE,
      TOP_PAD,
      TOP_HASH,
      TOP_EMIT
   } sha_top_state_type;

   localparam int unsigned ROUNDS     = 64;
   localparam int unsigned BLOCK_BITS = 512;
   localparam logic [7:0]  PAD_BYTE   = 8'h80;
   localparam logic [5:0]  LEN_POS    = 6'd56;
   localparam logic [5:0]  FILL_LAST  = 6'd63;
   localparam logic [5:0]  ROUND_LAST = 6'd63;
   localparam logic [2:0]  WORD_LAST  = 3'd7;

   localparam logic [31:0] IV_WORDS [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   // control from the message sequencer to the compression core
   typedef struct packed {
      logic        shift;       // push one byte into the block window
      logic [7:0]  shift_byte;
      logic        load_len;    // append the 64-bit length after 56 bytes
      logic [63:0] len_bits;
      logic        start;       // begin a 64-round compression
      logic        init;        // chain back to the initial hash
      logic [2:0]  word_sel;
   } sha_cmd_type;

   typedef struct packed {
      logic idle;
      logic done;
   } sha_stat_type;

   function automatic logic [31:0] rotr(input logic [31:0] x, input logic [4:0] n);
      logic [63:0] d;
      d = {x, x} >> n;
      return d[31:0];
   endfunction

   function automatic logic [31:0] big_s0(input logic [31:0] x);
      return rotr(x, 5'd2) ^ rotr(x, 5'd13) ^ rotr(x, 5'd22);
   endfunction

   function automatic logic [31:0] big_s1(input logic [31:0] x);
      return rotr(x, 5'd6) ^ rotr(x, 5'd11) ^ rotr(x, 5'd25);
   endfunction

   function automatic logic [31:0] small_s0(input logic [31:0] x);
      return rotr(x, 5'd7) ^ rotr(x, 5'd18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] small_s1(input logic [31:0] x);
      return rotr(x, 5'd17) ^ rotr(x, 5'd19) ^ (x >> 10);
   endfunction

endpackage

// ----- hw/rtl/sha_if.sv -----
interface sha_req_if;
   logic       valid;
   logic       ready;
   logic       opcode;
   logic [7:0] data_byte;

   modport source (output valid, output opcode, output data_byte, input ready);
   modport sink (input valid, input opcode, input data_byte, output ready);
endinterface

interface sha_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last;

   modport source (output valid, output digest_word, output word_index, output last,
                   input ready);
   modport sink (input valid, input digest_word, input word_index, input last,
                 output ready);
endinterface

// ----- hw/rtl/sha_core.sv -----
module sha_core import sha_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  sha_cmd_type  cmd,
   output sha_stat_type stat,
   output logic [31:0]  digest_word
);

   sha_core_state_type state_ff, state_in;
   logic [5:0]            round_ff, round_in;
   logic [BLOCK_BITS-1:0] window_ff, window_in;
   logic [31:0]           var_ff [8];
   logic [31:0]           var_next [8];
   logic [31:0]           chain_ff [8];

   logic [31:0] t1, t2, ch, mj, w_cur, w_new;

   // window word j sits at the top for j = 0; oldest word first
   function automatic logic [31:0] win_word(input logic [BLOCK_BITS-1:0] w,
                                            input int unsigned j);
      return w[BLOCK_BITS-1-32*j -: 32];
   endfunction

   // one round of the shared datapath
   always_comb begin
      w_cur = win_word(window_ff, 0);
      w_new = win_word(window_ff, 0) + small_s0(win_word(window_ff, 1))
            + win_word(window_ff, 9) + small_s1(win_word(window_ff, 14));
      ch = (var_ff[4] & var_ff[5]) ^ (~var_ff[4] & var_ff[6]);
      mj = (var_ff[0] & var_ff[1]) ^ (var_ff[0] & var_ff[2]) ^ (var_ff[1] & var_ff[2]);
      t1 = var_ff[7] + big_s1(var_ff[4]) + ch + ROUND_K[round_ff] + w_cur;
      t2 = big_s0(var_ff[0]) + mj;
      var_next[0] = t1 + t2;
      var_next[1] = var_ff[0];
      var_next[2] = var_ff[1];
      var_next[3] = var_ff[2];
      var_next[4] = var_ff[3] + t1;
      var_next[5] = var_ff[4];
      var_next[6] = var_ff[5];
      var_next[7] = var_ff[6];
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CORE_IDLE: begin
            if (cmd.start) state_in = CORE_ROUND;
         end
         CORE_ROUND: begin
            if (round_ff == ROUND_LAST) state_in = CORE_ADD;
         end
         CORE_ADD: state_in = CORE_IDLE;
         default: state_in = CORE_IDLE;
      endcase
   end

   always_comb begin
      stat.idle = (state_ff == CORE_IDLE);
      stat.done = (state_ff == CORE_ADD);
      round_in  = (state_ff == CORE_ROUND) ? round_ff + 6'd1 : 6'd0;
      if (state_ff == CORE_ROUND) begin
         window_in = {window_ff[BLOCK_BITS-33:0], w_new};
      end else if (cmd.load_len) begin
         window_in = {window_ff[BLOCK_BITS-65:0], cmd.len_bits};
      end else if (cmd.shift) begin
         window_in = {window_ff[BLOCK_BITS-9:0], cmd.shift_byte};
      end else begin
         window_in = window_ff;
      end
      digest_word = chain_ff[cmd.word_sel];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CORE_IDLE;
         round_ff <= 6'd0;
      end else begin
         state_ff <= state_in;
         round_ff <= round_in;
      end
   end

   always_ff @(posedge clock) begin
      window_ff <= window_in;
      for (int i = 0; i < 8; i++) begin
         if (state_ff == CORE_IDLE && cmd.start) begin
            var_ff[i] <= chain_ff[i];
         end else if (state_ff == CORE_ROUND) begin
            var_ff[i] <= var_next[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 8; i++) begin
         if (reset || cmd.init) begin
            chain_ff[i] <= IV_WORDS[i];
         end else if (state_ff == CORE_ADD) begin
            chain_ff[i] <= chain_ff[i] + var_ff[i];
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == CORE_ADD) |-> ($past(round_ff) == ROUND_LAST))
      else $error("chain update without a full round sweep");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == CORE_ROUND) |-> !cmd.shift && !cmd.load_len && !cmd.init)
      else $error("window or chain disturbed during compression");

endmodule

// ----- hw/rtl/sha256_stream_hasher.sv -----
// SHA-256 over a byte stream.
// req_chan carries one item per message byte (opcode absorb) or a finish item
// that closes the message. rsp_chan returns eight digest words per finish,
// word_index 0 first, last set on word 7. Absorb items give no result.
// Absorb: an absorb is taken while the block is idle; the 64th byte of a block
// starts a compression on the round unit, one round per cycle, 64 rounds
// then the chain add, and ready stays low until the compression is done.
// Finish: padding bytes go into the block window one per cycle while no
// compression runs (up to 56 per block), the length fills the last eight
// bytes, then the closing compression follows, one or two compressions in all.
// Reset: synchronous; chain goes to the initial hash, counts clear, the
// block starts a fresh message. No clearing pass.
// Receiver stall: digest words are held on rsp_chan until taken; req_chan
// stays not ready until the eighth word is taken, then the next message
// starts from the initial state.
module sha256_stream_hasher import sha_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   sha_req_if.sink   req_chan,
   sha_rsp_if.source rsp_chan
);

   sha_top_state_type state_ff, state_in;
   logic [5:0]  fill_ff, fill_in;        // bytes in the current block
   logic [63:0] count_ff, count_in;      // message bytes, wraps
   logic        final_ff, final_in;      // this compression closes the message
   logic        ret_pad_ff, ret_pad_in;  // padding continues after compression
   logic [2:0]  idx_ff, idx_in;

   sha_cmd_type  cmd;
   sha_stat_type stat;
   logic [31:0]  core_word;
   logic         req_take, rsp_take;

   sha_core u_core (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .digest_word (core_word)
   );

   assign req_take = req_chan.valid && req_chan.ready;
   assign rsp_take = rsp_chan.valid && rsp_chan.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         TOP_IDLE: begin
            if (req_take) begin
               if (fill_ff == FILL_LAST) begin
                  state_in = TOP_HASH;
               end else if (req_chan.opcode == OP_FINISH) begin
                  state_in = TOP_PAD;
               end
            end
         end
         TOP_PAD: begin
            if (fill_ff == LEN_POS || fill_ff == FILL_LAST) state_in = TOP_HASH;
         end
         TOP_HASH: begin
            if (stat.done) begin
               if (final_ff) state_in = TOP_EMIT;
               else if (ret_pad_ff) state_in = TOP_PAD;
               else state_in = TOP_IDLE;
            end
         end
         TOP_EMIT: begin
            if (rsp_take && idx_ff == WORD_LAST) state_in = TOP_IDLE;
         end
         default: state_in = TOP_IDLE;
      endcase
   end

   // outputs, core commands and counters
   always_comb begin
      req_chan.ready = (state_ff == TOP_IDLE);
      rsp_chan.valid = (state_ff == TOP_EMIT);
      rsp_chan.digest_word = core_word;
      rsp_chan.word_index  = idx_ff;
      rsp_chan.last        = (idx_ff == WORD_LAST);

      cmd            = '0;
      cmd.len_bits   = {count_ff[60:0], 3'b000};
      cmd.word_sel   = idx_ff;
      fill_in        = fill_ff;
      count_in       = count_ff;
      final_in       = final_ff;
      ret_pad_in     = ret_pad_ff;
      idx_in         = idx_ff;

      case (state_ff)
         TOP_IDLE: begin
            if (req_take) begin
               cmd.shift = 1'b1;
               fill_in   = fill_ff + 6'd1;
               if (req_chan.opcode == OP_FINISH) begin
                  cmd.shift_byte = PAD_BYTE;
                  ret_pad_in     = 1'b1;
               end else begin
                  cmd.shift_byte = req_chan.data_byte;
                  count_in       = count_ff + 64'd1;
                  ret_pad_in     = 1'b0;
               end
               final_in  = 1'b0;
               cmd.start = (fill_ff == FILL_LAST);
            end
         end
         TOP_PAD: begin
            if (fill_ff == LEN_POS) begin
               // length fills the last eight bytes of the block
               cmd.load_len = 1'b1;
               cmd.start    = 1'b1;
               final_in     = 1'b1;
               fill_in      = 6'd0;
            end else begin
               cmd.shift      = 1'b1;
               cmd.shift_byte = 8'h00;
               fill_in        = fill_ff + 6'd1;
               cmd.start      = (fill_ff == FILL_LAST);
            end
         end
         TOP_HASH: begin
            idx_in = 3'd0;
         end
         TOP_EMIT: begin
            if (rsp_take) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == WORD_LAST) begin
                  cmd.init   = 1'b1;
                  fill_in    = 6'd0;
                  count_in   = 64'd0;
                  final_in   = 1'b0;
                  ret_pad_in = 1'b0;
               end
            end
         end
         default: begin
            fill_in = fill_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= TOP_IDLE;
         fill_ff    <= 6'd0;
         count_ff   <= 64'd0;
         final_ff   <= 1'b0;
         ret_pad_ff <= 1'b0;
         idx_ff     <= 3'd0;
      end else begin
         state_ff   <= state_in;
         fill_ff    <= fill_in;
         count_ff   <= count_in;
         final_ff   <= final_in;
         ret_pad_ff <= ret_pad_in;
         idx_ff     <= idx_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> stat.idle)
      else $error("compression started while the core is busy");

   assert property (@(posedge clock) disable iff (reset)
      stat.done |-> (state_ff == TOP_HASH))
      else $error("compression finished outside the hash wait");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_take && idx_ff == WORD_LAST) |=> (fill_ff == 6'd0 && count_ff == 64'd0))
      else $error("message state not cleared after the digest");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == TOP_EMIT) |-> final_ff)
      else $error("digest emitted without the closing block");

endmodule

// ----- tb/sha256_digest_checker.sv -----
`timescale 1ns / 100ps

// Watches both channels, runs a SHA-256 model on the accepted items and
// checks every digest word against it in order.
module sha256_digest_checker import sha_pkg::*; (
   input  logic  clock,
   input  logic  reset,
   sha_req_if    req_mon,
   sha_rsp_if    rsp_mon,
   output int    error_count,
   output int    words_due
);

   localparam logic [7:0] PAD_MARK   = 8'h80;
   localparam int         LEN_OFFSET = 56;

   localparam logic [31:0] INIT_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_CONST [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_word_type;

   logic [7:0]      msg_block [64];
   int              fill;
   logic [63:0]     byte_total;
   logic [31:0]     chain [8];
   digest_word_type digest_queue [$];
   int              fail_total = 0;
   int              due_count  = 0;

   assign error_count = fail_total;
   assign words_due   = due_count;

   function automatic logic [31:0] ror(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic void restart_message();
      foreach (msg_block[k]) msg_block[k] = 8'h00;
      fill       = 0;
      byte_total = '0;
      foreach (chain[k]) chain[k] = INIT_HASH[k];
   endfunction

   // one 64-round compression of msg_block into chain
   function automatic void sha_compress();
      logic [31:0] w [16];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2, wr, w15, w2;
      for (int r = 0; r < 16; r++)
         w[r] = {msg_block[4*r], msg_block[4*r+1], msg_block[4*r+2], msg_block[4*r+3]};
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
      e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
      for (int r = 0; r < 64; r++) begin
         if (r < 16) begin
            wr = w[r];
         end else begin
            w15 = w[(r - 15) % 16];
            w2  = w[(r - 2) % 16];
            wr  = w[r % 16] + (ror(w15, 7) ^ ror(w15, 18) ^ (w15 >> 3))
                + w[(r - 7) % 16] + (ror(w2, 17) ^ ror(w2, 19) ^ (w2 >> 10));
            w[r % 16] = wr;
         end
         t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
            + ROUND_CONST[r] + wr;
         t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1;
         d = c; c = b; b = a; a = t1 + t2;
      end
      chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
      chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want_val);
      $display("%0t: digest mismatch on %s: got %h, want %h", $realtime, field, got,
               want_val);
      fail_total++;
   endtask

   always @(posedge clock) begin
      digest_word_type want;
      int              pos;
      logic [63:0]     bits;
      if (reset) begin
         restart_message();
         digest_queue.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.opcode == OP_ABSORB) begin
               msg_block[fill] = req_mon.data_byte;
               byte_total++;
               fill = (fill + 1) % 64;
               if (fill == 0) sha_compress();
            end else begin
               pos = fill;
               msg_block[pos] = PAD_MARK;
               pos++;
               // no room for the length: pad out and compress an extra block
               if (pos > LEN_OFFSET) begin
                  while (pos < 64) begin
                     msg_block[pos] = 8'h00;
                     pos++;
                  end
                  sha_compress();
                  pos = 0;
               end
               while (pos < LEN_OFFSET) begin
                  msg_block[pos] = 8'h00;
                  pos++;
               end
               bits = byte_total << 3;
               for (int j = 0; j < 8; j++)
                  msg_block[LEN_OFFSET + j] = bits[63 - 8*j -: 8];
               sha_compress();
               for (int k = 0; k < 8; k++)
                  digest_queue.push_back('{word: chain[k], index: 3'(k), last: (k == 7)});
               restart_message();
            end
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (digest_queue.size() == 0) begin
               report_mismatch("unexpected word", rsp_mon.digest_word, '0);
            end else begin
               want = digest_queue.pop_front();
               if (rsp_mon.digest_word != want.word)
                  report_mismatch("digest_word", rsp_mon.digest_word, want.word);
               if (rsp_mon.word_index != want.index)
                  report_mismatch("word_index", 32'(rsp_mon.word_index), 32'(want.index));
               if (rsp_mon.last != want.last)
                  report_mismatch("last", 32'(rsp_mon.last), 32'(want.last));
            end
         end
      end
      due_count = digest_queue.size();
   end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

// Top of the SHA-256 stream hasher bench. This module only makes stimulus
// and gives the verdict; all prediction and checking sits in the checker.
module testbench import sha_pkg::*; ();

   localparam int IDLE_PCT    = 7;        // idle cycles per hundred, each side
   localparam int HOLD_CYCLES = 400;      // long receiver hold-off
   localparam int ITEM_TARGET = 470;      // rough item budget for the whole run
   localparam int DRAIN_WAIT  = 200;      // extra wait once no digest word is due
   localparam int CYCLE_LIMIT = 500000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sha_req_if req_chan ();
   sha_rsp_if rsp_chan ();

   int   error_count;
   int   words_due;
   int   cycle_count = 0;
   int   items_sent  = 0;
   logic no_idle     = 1'b0;   // both sides run flat out while set
   int   hold_asked  = 0;      // bumped by stimulus to request a hold-off
   int   hold_served = 0;      // bumped by the receiver when one is done

   sha256_stream_hasher u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   sha256_digest_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .error_count (error_count),
      .words_due   (words_due)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Hard stop in case the block hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Offer one item and wait until it is taken. Valid is only dropped when
   // an idle cycle is actually inserted, so back-to-back items keep valid
   // high without a drop and re-raise in the same step.
   task automatic send_item(input sha_op_type op, input logic [7:0] value);
      while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.opcode    <= op;
      req_chan.data_byte <= value;
      do @(posedge clock); while (!req_chan.ready);
      items_sent++;
   endtask

   // len random bytes, then the finish item (its data byte is don't-care,
   // but we randomize it anyway so the field toggles on finish too)
   task automatic send_message(input int len);
      for (int k = 0; k < len; k++)
         send_item(OP_ABSORB, 8'($urandom_range(255)));
      send_item(OP_FINISH, 8'($urandom_range(255)));
   endtask

   // Receiver: random ready with ~7% drops, flat out during the no-idle
   // window, and one long hold-off on request. The hold is counted here so
   // the sender keeps pushing and backs up into the block.
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_chan.ready <= 1'b0;
         end else if (hold_asked != hold_served) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
            hold_served <= hold_served + 1;
         end else begin
            rsp_chan.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   initial begin
      int msg_idx;
      int pick;
      int len;

      req_chan.valid     = 1'b0;
      req_chan.opcode    = OP_ABSORB;
      req_chan.data_byte = 8'h00;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed ---
      // empty message right out of reset
      send_item(OP_FINISH, 8'h00);
      // "abc", the classic short vector
      send_item(OP_ABSORB, 8'h61);
      send_item(OP_ABSORB, 8'h62);
      send_item(OP_ABSORB, 8'h63);
      send_item(OP_FINISH, 8'hff);
      // byte extremes and the pad marker value itself as data
      send_item(OP_ABSORB, 8'h00);
      send_item(OP_ABSORB, 8'hff);
      send_item(OP_ABSORB, 8'h80);
      send_item(OP_ABSORB, 8'h7f);
      send_item(OP_FINISH, 8'h55);
      // empty again: state must have gone back to the initial hash
      send_item(OP_FINISH, 8'haa);

      // --- random ---
      // First three messages sit on the padding edges: 55 bytes (length fits
      // in the same block), 56 (needs the extra block), 64 (full block, then
      // a pad-only block). After that mostly short messages, some near the
      // edges, a few longer ones of up to 130 bytes.
      msg_idx = 0;
      while (items_sent < ITEM_TARGET) begin
         if (msg_idx == 4) no_idle <= 1'b1;
         if (msg_idx == 8) no_idle <= 1'b0;
         case (msg_idx)
            0: len = 55;
            1: len = 56;
            2: len = 64;
            9: begin
               // short message into a stalled receiver; the next message's
               // bytes then back up against the held digest
               hold_asked <= hold_asked + 1;
               len = 3;
            end
            default: begin
               pick = $urandom_range(99);
               if (pick < 65)
                  len = $urandom_range(10);
               else if (pick < 85)
                  len = $urandom_range(54, 65);
               else
                  len = $urandom_range(11, 130);
            end
         endcase
         send_message(len);
         msg_idx++;
      end
      req_chan.valid <= 1'b0;

      // let the checker register the last finish, then drain
      @(posedge clock);
      while (words_due != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (error_count == 0 && words_due == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
